// ===== hw/rtl/fpn_pkg.sv =====
// ---------------------------------------------------------------------------
// fpn_pkg: shared types and constants for the fractal noise generator
// Word formats, fixed-point widths, gradient selection and the per-octave
// normalization constants.
// ---------------------------------------------------------------------------
`default_nettype none

package fpn_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int TABLE_AW     = 8;
    localparam int DIM_W        = 10;
    localparam int MAX_LOG2_DIM = 10;
    localparam int MAX_OCTAVES  = 8;
    localparam int ADDR_W       = 30;
    localparam int COORD_W      = 24;
    localparam int FADE_STEPS   = 4;
    localparam int P_W          = 24;
    localparam int G_W          = 19;
    localparam int N_W          = 20;
    localparam int SUM_W        = 22;
    localparam int RECIP_W      = 18;
    localparam int CFG_IDX_W    = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LOG2  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LOG2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LOG2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 3'd4;

    // Function codes of a request word.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    typedef struct packed {
        logic                func;
        logic [7:0]          entry_index;
        logic [7:0]          entry_value;
        logic [DIM_W-1:0]    voxel_x;
        logic [DIM_W-1:0]    voxel_y;
        logic [DIM_W-1:0]    voxel_z;
    } req_t;

    typedef struct packed {
        logic [7:0]          density;
        logic [ADDR_W-1:0]   texel_address;
    } rsp_t;

    // Data handed from one fade cell to the next.
    typedef struct packed {
        logic [FRAC_BITS-1:0]  t;
        logic signed [P_W-1:0] p;
        logic signed [P_W-1:0] bias;
    } fade_stage_t;

    // Gradient dot product for one corner, selected by the low hash bits.
    function automatic logic signed [G_W-1:0] grad_q(
        input logic [3:0]         h,
        input logic signed [17:0] x,
        input logic signed [17:0] y,
        input logic signed [17:0] z
    );
        logic signed [G_W-1:0] u;
        logic signed [G_W-1:0] v;
        u = (h < 4'd8) ? {x[17], x} : {y[17], y};
        if (h < 4'd4)
            v = {y[17], y};
        else if (h == 4'd12 || h == 4'd14)
            v = {x[17], x};
        else
            v = {z[17], z};
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    // Rounded 2^(k-1+F) / (2^k - 1) for k octaves.
    function automatic logic [RECIP_W-1:0] recip_q(input logic [3:0] k);
        logic [RECIP_W-1:0] r;
        case (k)
            4'd1:    r = 18'd65536;
            4'd2:    r = 18'd43691;
            4'd3:    r = 18'd37449;
            4'd4:    r = 18'd34953;
            4'd5:    r = 18'd33825;
            4'd6:    r = 18'd33288;
            4'd7:    r = 18'd33026;
            default: r = 18'd32897;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fpn_fade_cell.sv =====
// ---------------------------------------------------------------------------
// fpn_fade_cell: one step of the fade polynomial
// Multiplies the running polynomial by the weight, rescales, adds the bias
// and hands the result to the next cell every cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module fpn_fade_cell
    import fpn_pkg::*;
(
    input  wire logic        clk,
    input  fade_stage_t      stage_in,
    output fade_stage_t      stage_out
);

    logic signed [FRAC_BITS+P_W:0] prod;
    logic signed [FRAC_BITS+P_W:0] prod_sh;
    logic signed [P_W-1:0]         p_next;

    // Product of the weight and the polynomial, floored back to Q.F.
    always_comb
    begin
        prod    = $signed({1'b0, stage_in.t}) * stage_in.p;
        prod_sh = prod >>> FRAC_BITS;
        p_next  = $signed(prod_sh[P_W-1:0]) + stage_in.bias;
    end

    always_ff @(posedge clk)
    begin
        stage_out.t    <= stage_in.t;
        stage_out.p    <= p_next;
        stage_out.bias <= '0;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fractal_perlin_noise_voxel_gen.sv =====
// ---------------------------------------------------------------------------
// fractal_perlin_noise_voxel_gen: fractal 3D gradient-noise texel generator
// Loads the permutation table and turns voxel coordinates into noise texels.
// ---------------------------------------------------------------------------
// A load word writes one permutation entry. An evaluate word runs, for
// each octave, the 14 dependent reads of the permutation table, the seven
// lerps on the shared interpolation multiplier and one accumulation step,
// then normalization and the output stage. The fade weights run through a
// row of four multiply cells while the table is read. All 256 entries must
// be loaded before the first evaluation. Configuration must be written only
// while the block is idle; the block itself does not enforce this. The
// response register lets a finished texel wait while a new word is accepted.
// No new word is accepted while an evaluation is in progress.
`default_nettype none

module fractal_perlin_noise_voxel_gen
    import fpn_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  req_t                      req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output rsp_t                      rsp,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [3:0]           cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOOK = 6'b000010,
        ST_LERP = 6'b000100,
        ST_ACC  = 6'b001000,
        ST_NORM = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    localparam logic signed [P_W-1:0] FADE_C6  = P_W'(6);
    localparam logic signed [P_W-1:0] FADE_C15 = P_W'(15 << FRAC_BITS);
    localparam logic signed [P_W-1:0] FADE_C10 = P_W'(10 << FRAC_BITS);
    localparam logic signed [17:0]    ONE_18   = 18'sd65536;

    state_t                 state_reg, state_next;
    logic [3:0]             wl_reg, hl_reg, dl_reg, oct_reg, ns_reg;
    logic [3:0]             cnt_reg;
    logic [2:0]             idx_reg;
    logic [3:0]             total_reg;
    logic [COORD_W-1:0]     cx_reg, cy_reg, cz_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [7:0]             hash_reg [0:5];
    logic signed [G_W-1:0]  grad_reg [0:7];
    logic [FRAC_BITS-1:0]   fade_reg [0:2];
    logic signed [N_W-1:0]  lerp_reg [0:5];
    logic signed [N_W-1:0]  noise_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [FRAC_BITS-1:0]   frac_reg;
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg;
    logic [7:0]             perm_mem [0:(1<<TABLE_AW)-1];
    logic [7:0]             rdata_reg;

    logic                   req_fire;
    logic [3:0]             wl_c, hl_c, dl_c, oct_c;
    logic [DIM_W-1:0]       mx, my, mz;
    logic [13:0]            sx, sy, sz;
    logic [29:0]            shx, shy, shz;
    logic [ADDR_W-1:0]      addr_calc;
    logic [4:0]             whl;
    logic [7:0]             cell_x, cell_y, cell_z, raddr;
    fade_stage_t            chain [0:FADE_STEPS];
    logic [2:0]             corner;
    logic signed [17:0]     x0, y0, z0, x1, y1, z1;
    logic [FRAC_BITS-1:0]   lt;
    logic signed [N_W-1:0]  la, lb, lres;
    logic signed [N_W:0]    ldiff;
    logic signed [N_W+FRAC_BITS+1:0] lprod, lprod_sh;
    logic signed [SUM_W-1:0] noise_shift;
    logic signed [SUM_W+RECIP_W:0] nprod, nprod_sh;
    logic signed [SUM_W+RECIP_W:0] mval;
    logic [FRAC_BITS+7:0]   dens_full;
    logic                   last_oct;
    logic                   rsp_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg  <= 4'd8;
            hl_reg  <= 4'd8;
            dl_reg  <= 4'd8;
            oct_reg <= 4'd6;
            ns_reg  <= 4'd4;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WIDTH_LOG2:  wl_reg  <= cfg_data;
                CFG_HEIGHT_LOG2: hl_reg  <= cfg_data;
                CFG_DEPTH_LOG2:  dl_reg  <= cfg_data;
                CFG_OCTAVES:     oct_reg <= cfg_data;
                CFG_SCALE:       ns_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Clamped sizes, masked coordinates and their scaled noise positions.
    always_comb
    begin
        wl_c  = (wl_reg > 4'(MAX_LOG2_DIM)) ? 4'(MAX_LOG2_DIM) : wl_reg;
        hl_c  = (hl_reg > 4'(MAX_LOG2_DIM)) ? 4'(MAX_LOG2_DIM) : hl_reg;
        dl_c  = (dl_reg > 4'(MAX_LOG2_DIM)) ? 4'(MAX_LOG2_DIM) : dl_reg;
        oct_c = (oct_reg == 4'd0) ? 4'd1 :
                (oct_reg > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : oct_reg;
        mx    = req.voxel_x & ~({DIM_W{1'b1}} << wl_c);
        my    = req.voxel_y & ~({DIM_W{1'b1}} << hl_c);
        mz    = req.voxel_z & ~({DIM_W{1'b1}} << dl_c);
        sx    = 14'(mx) * 14'(ns_reg);
        sy    = 14'(my) * 14'(ns_reg);
        sz    = 14'(mz) * 14'(ns_reg);
        shx   = {sx, 16'b0} >> wl_c;
        shy   = {sy, 16'b0} >> hl_c;
        shz   = {sz, 16'b0} >> dl_c;
        whl   = 5'(wl_c) + 5'(hl_c);
        addr_calc = ADDR_W'(mx) + (ADDR_W'(my) << wl_c) + (ADDR_W'(mz) << whl);
    end

    // Table read address for each step of the hash lookup.
    always_comb
    begin
        cell_x = cx_reg[FRAC_BITS+7:FRAC_BITS];
        cell_y = cy_reg[FRAC_BITS+7:FRAC_BITS];
        cell_z = cz_reg[FRAC_BITS+7:FRAC_BITS];
        case (cnt_reg)
            4'd0:    raddr = cell_x;
            4'd1:    raddr = cell_x + 8'd1;
            4'd2:    raddr = hash_reg[0] + cell_y;
            4'd3:    raddr = hash_reg[0] + cell_y + 8'd1;
            4'd4:    raddr = hash_reg[1] + cell_y;
            4'd5:    raddr = hash_reg[1] + cell_y + 8'd1;
            4'd6:    raddr = hash_reg[2] + cell_z;
            4'd7:    raddr = hash_reg[2] + cell_z + 8'd1;
            4'd8:    raddr = hash_reg[4] + cell_z;
            4'd9:    raddr = hash_reg[4] + cell_z + 8'd1;
            4'd10:   raddr = hash_reg[3] + cell_z;
            4'd11:   raddr = hash_reg[3] + cell_z + 8'd1;
            4'd12:   raddr = hash_reg[5] + cell_z;
            default: raddr = hash_reg[5] + cell_z + 8'd1;
        endcase
    end

    // Permutation table: written by load words, read once per cycle.
    always_ff @(posedge clk)
    begin
        if (req_fire && req.func == FUNC_LOAD)
            perm_mem[req.entry_index] <= req.entry_value;
        rdata_reg <= perm_mem[raddr];
    end

    // Fade cells: x, y and z fractions enter on the first three lookup steps.
    always_comb
    begin
        chain[0].t    = (cnt_reg == 4'd0) ? cx_reg[FRAC_BITS-1:0] :
                        (cnt_reg == 4'd1) ? cy_reg[FRAC_BITS-1:0] :
                                            cz_reg[FRAC_BITS-1:0];
        chain[0].p    = FADE_C6 * $signed({{(P_W-FRAC_BITS){1'b0}}, chain[0].t})
                        - FADE_C15;
        chain[0].bias = FADE_C10;
    end

    for (genvar i = 0; i < FADE_STEPS; i++)
    begin : g_fade
        fpn_fade_cell u_cell (
            .clk       (clk),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    // Corner offsets for the gradient of the word now arriving.
    always_comb
    begin
        corner = 3'(cnt_reg - 4'd7);
        x0 = $signed({2'b00, cx_reg[FRAC_BITS-1:0]});
        y0 = $signed({2'b00, cy_reg[FRAC_BITS-1:0]});
        z0 = $signed({2'b00, cz_reg[FRAC_BITS-1:0]});
        x1 = x0 - ONE_18;
        y1 = y0 - ONE_18;
        z1 = z0 - ONE_18;
    end

    // Shared interpolation unit: seven lerps per octave.
    always_comb
    begin
        case (cnt_reg)
            4'd0:
            begin
                lt = fade_reg[0]; la = N_W'(grad_reg[0]); lb = N_W'(grad_reg[2]);
            end
            4'd1:
            begin
                lt = fade_reg[0]; la = N_W'(grad_reg[4]); lb = N_W'(grad_reg[6]);
            end
            4'd2:
            begin
                lt = fade_reg[0]; la = N_W'(grad_reg[1]); lb = N_W'(grad_reg[3]);
            end
            4'd3:
            begin
                lt = fade_reg[0]; la = N_W'(grad_reg[5]); lb = N_W'(grad_reg[7]);
            end
            4'd4:
            begin
                lt = fade_reg[1]; la = lerp_reg[0]; lb = lerp_reg[1];
            end
            4'd5:
            begin
                lt = fade_reg[1]; la = lerp_reg[2]; lb = lerp_reg[3];
            end
            default:
            begin
                lt = fade_reg[2]; la = lerp_reg[4]; lb = lerp_reg[5];
            end
        endcase
        ldiff    = {lb[N_W-1], lb} - {la[N_W-1], la};
        lprod    = $signed({1'b0, lt}) * ldiff;
        lprod_sh = lprod >>> FRAC_BITS;
        lres     = la + $signed(lprod_sh[N_W-1:0]);
    end

    // Octave weighting, normalization and the final byte.
    always_comb
    begin
        noise_shift = SUM_W'(noise_reg) >>> idx_reg;
        last_oct    = ({1'b0, idx_reg} == total_reg - 4'd1);
        nprod       = sum_reg * $signed({1'b0, recip_q(total_reg)});
        nprod_sh    = nprod >>> FRAC_BITS;
        mval        = (nprod_sh + (1 <<< FRAC_BITS)) >>> 1;
        dens_full   = ({frac_reg, 8'b0} - {8'b0, frac_reg});
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (req_fire && req.func == FUNC_EVAL) state_next = ST_LOOK;
            ST_LOOK: if (cnt_reg == 4'd14) state_next = ST_LERP;
            ST_LERP: if (cnt_reg == 4'd6) state_next = ST_ACC;
            ST_ACC:  state_next = last_oct ? ST_NORM : ST_LOOK;
            ST_NORM: state_next = ST_DONE;
            ST_DONE: if (rsp_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE || state_reg == ST_ACC)
                cnt_reg <= '0;
            else if (state_reg == ST_LOOK && cnt_reg == 4'd14)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 4'd1;
            if (state_reg == ST_IDLE)
                idx_reg <= '0;
            else if (state_reg == ST_ACC)
                idx_reg <= idx_reg + 3'd1;
            if (state_reg == ST_DONE && rsp_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cx_reg    <= shx[COORD_W-1:0];
            cy_reg    <= shy[COORD_W-1:0];
            cz_reg    <= shz[COORD_W-1:0];
            addr_reg  <= addr_calc;
            total_reg <= oct_c;
            sum_reg   <= '0;
        end
        if (state_reg == ST_LOOK)
        begin
            if (cnt_reg >= 4'd1 && cnt_reg <= 4'd6)
                hash_reg[3'(cnt_reg - 4'd1)] <= rdata_reg;
            if (cnt_reg >= 4'd7)
                grad_reg[corner] <= grad_q(rdata_reg[3:0],
                                           corner[1] ? x1 : x0,
                                           corner[2] ? y1 : y0,
                                           corner[0] ? z1 : z0);
            if (cnt_reg >= 4'd4 && cnt_reg <= 4'd6)
                fade_reg[2'(cnt_reg - 4'd4)] <= chain[FADE_STEPS].p[FRAC_BITS-1:0];
        end
        if (state_reg == ST_LERP)
        begin
            if (cnt_reg == 4'd6)
                noise_reg <= lres;
            else
                lerp_reg[3'(cnt_reg)] <= lres;
        end
        if (state_reg == ST_ACC)
        begin
            sum_reg <= sum_reg + noise_shift;
            cx_reg  <= {cx_reg[COORD_W-2:0], 1'b0};
            cy_reg  <= {cy_reg[COORD_W-2:0], 1'b0};
            cz_reg  <= {cz_reg[COORD_W-2:0], 1'b0};
        end
        if (state_reg == ST_NORM)
            frac_reg <= mval[FRAC_BITS-1:0];
        if (state_reg == ST_DONE && rsp_free)
        begin
            rsp_reg.density       <= dens_full[FRAC_BITS+7:FRAC_BITS];
            rsp_reg.texel_address <= addr_reg;
        end
    end

endmodule

`default_nettype wire
